@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RECTANGLE encrypt core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style property checked on every clock edge outside reset.
`define RBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: when ante holds, cons must hold.
`define RBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rbe_pkg.sv @@
// Types, constants and round functions for the RECTANGLE encrypt core.
package rbe_pkg;

  localparam int NUM_ROUNDS = 25;
  localparam int KEY_DEPTH  = NUM_ROUNDS + 1;
  localparam int SLOT_W     = 5;
  localparam int BLOCK_W    = 64;
  localparam int ROW_W      = 16;

  localparam int ROT_ROW1 = 1;
  localparam int ROT_ROW2 = 12;
  localparam int ROT_ROW3 = 13;

  localparam logic [SLOT_W-1:0] FINAL_KEY_SLOT = SLOT_W'(NUM_ROUNDS);

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_LOAD    = 1'b1
  } rbe_cmd_t;

  // One pipeline stage: valid flag plus the item moving along with it.
  typedef struct packed {
    logic                valid;
    logic                is_load;
    logic [SLOT_W-1:0]   key_slot;
    logic [BLOCK_W-1:0]  data;
  } rbe_stage_t;

  function automatic logic [ROW_W-1:0] rotl16(input logic [ROW_W-1:0] v, input int amt);
    rotl16 = (v << amt) | (v >> (ROW_W - amt));
  endfunction

  // Bitsliced SubColumn S-box, row 0 is the low bit of each column nibble.
  function automatic logic [BLOCK_W-1:0] sub_column(input logic [BLOCK_W-1:0] blk);
    logic [ROW_W-1:0] a0, a1, a2, a3, n1, t3, t6, t8, b0, b1, b2, b3;
    a0 = blk[0*ROW_W +: ROW_W];
    a1 = blk[1*ROW_W +: ROW_W];
    a2 = blk[2*ROW_W +: ROW_W];
    a3 = blk[3*ROW_W +: ROW_W];
    n1 = ~a1;
    t3 = a2 ^ a3;
    b0 = (a0 & n1) ^ t3;
    t6 = a0 ^ (a3 | n1);
    b1 = a2 ^ t6;
    t8 = a1 ^ a2;
    b3 = t8 ^ (t3 & t6);
    b2 = t6 ^ (b0 | t8);
    sub_column = {b3, b2, b1, b0};
  endfunction

  // Full round: key XOR, SubColumn, ShiftRow.
  function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] blk,
                                                    input logic [BLOCK_W-1:0] rkey);
    logic [BLOCK_W-1:0] s;
    s = sub_column(blk ^ rkey);
    enc_round = {rotl16(s[3*ROW_W +: ROW_W], ROT_ROW3),
                 rotl16(s[2*ROW_W +: ROW_W], ROT_ROW2),
                 rotl16(s[1*ROW_W +: ROW_W], ROT_ROW1),
                 s[0*ROW_W +: ROW_W]};
  endfunction

endpackage

@@ rtl/rbe_in_if.sv @@
// Input channel of the RECTANGLE encrypt core: command, key slot and data word.
interface rbe_in_if import rbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [SLOT_W-1:0]   key_slot;
  logic [BLOCK_W-1:0]  data_word;

  modport source (output valid, output command, output key_slot, output data_word,
                  input ready);
  modport sink   (input valid, input command, input key_slot, input data_word,
                  output ready);
endinterface

@@ rtl/rbe_out_if.sv @@
// Result channel of the RECTANGLE encrypt core: one ciphertext block per beat.
interface rbe_out_if import rbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BLOCK_W-1:0]  ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

@@ rtl/rbe_round.sv @@
// One round stage of the encrypt pipeline, holding its own round key register.
module rbe_round import rbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [SLOT_W-1:0] round_idx,
  input  rbe_stage_t        stg_in,
  output rbe_stage_t        stg_out
);

  logic               valid_r;
  logic               valid_nxt;
  logic               is_load_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [BLOCK_W-1:0] data_r;
  logic [BLOCK_W-1:0] data_nxt;
  logic [BLOCK_W-1:0] rkey_r;
  logic               key_wr;

  // A load passing this stage updates the key for every item behind it only.
  assign key_wr    = advance && stg_in.valid && stg_in.is_load && (stg_in.key_slot == round_idx);
  assign valid_nxt = advance ? stg_in.valid : valid_r;
  assign data_nxt  = stg_in.is_load ? stg_in.data : enc_round(stg_in.data, rkey_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_load_r <= stg_in.is_load;
      slot_r    <= stg_in.key_slot;
      data_r    <= data_nxt;
    end
    if (key_wr) begin
      rkey_r <= stg_in.data;
    end
  end

  assign stg_out = '{valid: valid_r, is_load: is_load_r, key_slot: slot_r, data: data_r};

endmodule

@@ rtl/rbe_out_buf.sv @@
// Final key addition and two-entry output buffer of the RECTANGLE encrypt core.
`include "assert_macros.svh"
module rbe_out_buf import rbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rbe_stage_t  stg_in,
  output logic        advance,
  rbe_out_if.source   out_ch
);

  logic               v0_r, v0_nxt, v1_r, v1_nxt;
  logic [BLOCK_W-1:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [BLOCK_W-1:0] fkey_r;
  logic [BLOCK_W-1:0] result;
  logic               push;
  logic               pop;
  logic               key_wr;

  // The pipeline moves whenever the buffer has room after this cycle's pop.
  assign advance = !v1_r || out_ch.ready;

  assign result = stg_in.data ^ fkey_r;
  assign push   = advance && stg_in.valid && !stg_in.is_load;
  assign key_wr = advance && stg_in.valid && stg_in.is_load &&
                  (stg_in.key_slot == FINAL_KEY_SLOT);
  assign pop    = v0_r && out_ch.ready;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      d0_nxt = d1_r;
      v0_nxt = v1_r;
      v1_nxt = 1'b0;
    end
    if (push) begin
      if (!v0_nxt) begin
        d0_nxt = result;
        v0_nxt = 1'b1;
      end else begin
        d1_nxt = result;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
    if (key_wr) begin
      fkey_r <= stg_in.data;
    end
  end

  assign out_ch.valid      = v0_r;
  assign out_ch.ciphertext = d0_r;

  `RBE_ASSERT(a_buf_order, !v1_r || v0_r, "second buffer entry held without a head entry")
  `RBE_ASSERT_NEXT(a_push_seen, push && !v0_r, v0_r, "pushed block did not reach the head")
  `RBE_ASSERT_NEXT(a_pop_refill, pop && v1_r, v0_r, "second entry lost on a pop")

endmodule

@@ rtl/rectangle_block_encrypt_core.sv @@
// Top level of the pipelined RECTANGLE 64-bit block encrypt core.
//
//   channel   dir   beat contents                         completes when
//   in_ch     in    command, key_slot, data_word          valid && ready
//   out_ch    out   ciphertext                            valid && ready
//
// Each beat runs through one register stage per round (25 stages) and then the
// final key addition into a two-entry output buffer; one beat can enter every
// cycle while the pipeline advances, set by the round stage being one round deep.
// Reset clears the valid bits only; round keys are undefined until loaded.
// A stall on out_ch freezes the whole pipeline only once both buffer entries
// are full, so input keeps being taken while a finished block waits.
`include "assert_macros.svh"
module rectangle_block_encrypt_core import rbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rbe_in_if.sink     in_ch,
  rbe_out_if.source  out_ch
);

  // stg[r] feeds round r; stg[NUM_ROUNDS] feeds the final key addition.
  rbe_stage_t stg [NUM_ROUNDS+1];
  logic       advance;

  // Loads travel down the pipeline like blocks, so each round key register is
  // rewritten exactly between the blocks accepted before and after the load.
  assign in_ch.ready = advance;
  assign stg[0] = '{valid:    in_ch.valid,
                    is_load:  (in_ch.command == CMD_LOAD),
                    key_slot: in_ch.key_slot,
                    data:     in_ch.data_word};

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    rbe_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .round_idx (SLOT_W'(r)),
      .stg_in    (stg[r]),
      .stg_out   (stg[r+1])
    );
  end

  rbe_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg_in  (stg[NUM_ROUNDS]),
    .advance (advance),
    .out_ch  (out_ch)
  );

  // A taken load beat enters the first round stage, a stall keeps that stage's beat, and a waiting result holds.
  `RBE_ASSERT_NEXT(a_first_stage_load, in_ch.valid && in_ch.ready && (in_ch.command == CMD_LOAD),
    stg[1].valid && stg[1].is_load, "load beat did not enter the first round stage")
  `RBE_ASSERT_NEXT(a_stall_holds, !advance && stg[1].valid,
    stg[1].valid, "first round stage dropped a beat during a stall")
  `RBE_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.ciphertext), "waiting result beat changed")

endmodule

@@ verif/rectangle_block_encrypt_core_tb.sv @@
// Self-checking testbench for the pipelined RECTANGLE block encrypt core.
`timescale 1ns / 100ps

module rectangle_block_encrypt_core_tb;
  import rbe_pkg::*;

  // Quiet cycles the driver waits after the result queue empties before a
  // settling beat may enter. The core is 25 round stages deep plus a
  // two-entry output buffer.
  localparam int SETTLE_CYCLES   = 40;
  localparam int DRAIN_CYCLES    = 60;
  localparam int TOTAL_ITEMS     = 750;
  localparam int PRESSURE_AT     = 5;
  localparam int PRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int REPORT_LIMIT    = 10;

  // One input beat as the stimulus generator sees it. When settle is set, the
  // driver holds this beat back until the pipeline has fully drained, so that
  // key loads never overtake or trail blocks that are still in flight.
  typedef struct {
    rbe_cmd_t            cmd;
    logic [SLOT_W-1:0]   slot;
    logic [BLOCK_W-1:0]  word;
    bit                  settle;
  } core_cmd_t;

  logic clk;
  logic rst_n;

  rbe_in_if  in_ch ();
  rbe_out_if out_ch ();

  rectangle_block_encrypt_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Commands waiting to be driven, ciphertexts waiting to come out, and the
  // testbench's own copy of the round key table.
  core_cmd_t          cmd_queue[$];
  logic [BLOCK_W-1:0] expected_ciphertexts[$];
  logic [BLOCK_W-1:0] round_keys[KEY_DEPTH];

  int          fail_count;
  int          mismatch_count;
  int          results_seen;
  int          idle_cycles;
  logic [31:0] cycle_count = '0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction.
  // ---------------------------------------------------------------------------

  // The RECTANGLE S-box applied to one column nibble, row 0 in the low bit.
  function automatic logic [3:0] sbox_nibble(input logic [3:0] x);
    case (x)
      4'h0: return 4'h6;
      4'h1: return 4'h5;
      4'h2: return 4'hC;
      4'h3: return 4'hA;
      4'h4: return 4'h1;
      4'h5: return 4'hE;
      4'h6: return 4'h7;
      4'h7: return 4'h9;
      4'h8: return 4'hB;
      4'h9: return 4'h0;
      4'hA: return 4'h3;
      4'hB: return 4'hD;
      4'hC: return 4'h8;
      4'hD: return 4'hF;
      4'hE: return 4'h4;
      default: return 4'h2;
    endcase
  endfunction

  // SubColumn done column by column with the lookup above rather than with
  // the bitsliced gate network that the core uses.
  function automatic logic [BLOCK_W-1:0] sub_columns(input logic [BLOCK_W-1:0] blk);
    logic [BLOCK_W-1:0] res;
    logic [3:0]         nib;
    res = '0;
    for (int c = 0; c < ROW_W; c++) begin
      nib = sbox_nibble({blk[3*ROW_W+c], blk[2*ROW_W+c], blk[ROW_W+c], blk[c]});
      res[c]         = nib[0];
      res[ROW_W+c]   = nib[1];
      res[2*ROW_W+c] = nib[2];
      res[3*ROW_W+c] = nib[3];
    end
    return res;
  endfunction

  // Left rotation of one row, taken as a window out of the row doubled.
  function automatic logic [ROW_W-1:0] rotate_row(input logic [ROW_W-1:0] v, input int n);
    logic [2*ROW_W-1:0] twice;
    twice = {v, v};
    return twice[(2*ROW_W-1-n) -: ROW_W];
  endfunction

  function automatic logic [BLOCK_W-1:0] rectangle_encrypt(input logic [BLOCK_W-1:0] plain);
    logic [BLOCK_W-1:0] st;
    st = plain;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      st = sub_columns(st ^ round_keys[r]);
      st = {rotate_row(st[3*ROW_W +: ROW_W], ROT_ROW3),
            rotate_row(st[2*ROW_W +: ROW_W], ROT_ROW2),
            rotate_row(st[ROW_W +: ROW_W], ROT_ROW1),
            st[0 +: ROW_W]};
    end
    return st ^ round_keys[NUM_ROUNDS];
  endfunction

  // ---------------------------------------------------------------------------
  // Idle timing shared by both sides.
  // ---------------------------------------------------------------------------

  // Most gaps are zero or short and a few are long. One quarter of the time, while
  // cycle_count[9:8] is zero, is a quiet window with no idling at all on either side.
  function automatic int idle_len();
    int r;
    if (cycle_count[9:8] == 2'd0) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------

  // Random 64-bit words, biased toward the patterns that tend to break an
  // S-box or a rotation: all zeros, all ones, single bits and alternations.
  function automatic logic [BLOCK_W-1:0] pick_word();
    logic [BLOCK_W-1:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, BLOCK_W-1);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      4:       return 64'h5555_5555_5555_5555;
      5:       return 64'hAAAA_AAAA_AAAA_AAAA;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_cmd(input rbe_cmd_t c, input logic [SLOT_W-1:0] s,
                           input logic [BLOCK_W-1:0] w, input bit settle);
    core_cmd_t item;
    item.cmd    = c;
    item.slot   = s;
    item.word   = w;
    item.settle = settle;
    cmd_queue.push_back(item);
  endtask

  // A slot above the table is a load that the core must drop without a trace.
  function automatic logic [SLOT_W-1:0] stray_slot();
    return SLOT_W'($urandom_range(KEY_DEPTH, (1 << SLOT_W) - 1));
  endfunction

  initial begin
    logic [BLOCK_W-1:0] key_word;
    int                 phase;
    int                 must_load;
    int                 block_count;
    bit                 lead;

    rst_n = 1'b0;

    // Directed part. Every slot is written before the first block, since the
    // table holds nothing defined after reset. The first and last slots take
    // the extreme key values.
    for (int s = 0; s < KEY_DEPTH; s++) begin
      if (s == 0) begin
        key_word = '1;
      end else if (s == KEY_DEPTH - 1) begin
        key_word = '0;
      end else begin
        key_word = {$urandom, $urandom};
      end
      queue_cmd(CMD_LOAD, SLOT_W'(s), key_word, 1'b0);
    end
    // Loads to the slot just past the table and to the top slot are dropped.
    queue_cmd(CMD_LOAD, SLOT_W'(KEY_DEPTH), '1, 1'b0);
    queue_cmd(CMD_LOAD, '1, '0, 1'b0);
    // Plaintext extremes; the key slot field of an encrypt is don't-care.
    queue_cmd(CMD_ENCRYPT, '0, '0, 1'b1);
    queue_cmd(CMD_ENCRYPT, '1, '1, 1'b0);
    queue_cmd(CMD_ENCRYPT, '0, 64'h5555_5555_5555_5555, 1'b0);
    queue_cmd(CMD_ENCRYPT, '1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_cmd(CMD_ENCRYPT, 5'd7, 64'h0000_0000_0000_0001, 1'b0);
    queue_cmd(CMD_ENCRYPT, 5'd25, 64'h8000_0000_0000_0000, 1'b0);
    queue_cmd(CMD_ENCRYPT, 5'd13, {$urandom, $urandom}, 1'b0);
    // A long run of blocks that never waits, so the receiver's long hold
    // early in the run always finds beats on offer and fills the core.
    for (int i = 0; i < 60; i++) begin
      queue_cmd(CMD_ENCRYPT, '0, pick_word(), 1'b0);
    end

    // Random part, in key phases. Each phase drains the core, rewrites keys,
    // lets the loads settle, then streams blocks mixed with dropped loads.
    // The first two phases use the all-zero and all-one key sets.
    phase = 0;
    while (cmd_queue.size() < TOTAL_ITEMS) begin
      lead      = 1'b1;
      must_load = $urandom_range(0, KEY_DEPTH - 1);
      for (int s = 0; s < KEY_DEPTH; s++) begin
        if (phase < 2 || s == must_load || $urandom_range(0, 2) == 0) begin
          if (phase == 0) begin
            key_word = '0;
          end else if (phase == 1) begin
            key_word = '1;
          end else begin
            key_word = pick_word();
          end
          queue_cmd(CMD_LOAD, SLOT_W'(s), key_word, lead);
          lead = 1'b0;
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        queue_cmd(CMD_LOAD, stray_slot(), pick_word(), 1'b0);
      end
      block_count = $urandom_range(60, 110);
      for (int i = 0; i < block_count && cmd_queue.size() < TOTAL_ITEMS; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          queue_cmd(CMD_LOAD, stray_slot(), pick_word(), 1'b0);
        end
        queue_cmd(CMD_ENCRYPT, SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1)),
                  pick_word(), (i == 0));
      end
      phase++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every ciphertext to arrive, then
    // give the core time to show any result it should not produce.
    @(posedge clk);
    while (cmd_queue.size() != 0 || expected_ciphertexts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_ciphertexts.size() != 0) begin
      $display("%0d ciphertexts never arrived", expected_ciphertexts.size());
    end
    if (fail_count == 0 && expected_ciphertexts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. The beat on offer is always the head of cmd_queue; it is popped,
  // and its effect predicted, at the edge where the core takes it. A beat
  // that is refused keeps valid high untouched until it is taken.
  // ---------------------------------------------------------------------------
  int gap_left;
  int settle_count;

  always @(posedge clk) begin
    core_cmd_t taken;
    core_cmd_t head;
    bit        offering;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.command   <= CMD_ENCRYPT;
      in_ch.key_slot  <= '0;
      in_ch.data_word <= '0;
      gap_left     = 0;
      settle_count = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        taken = cmd_queue.pop_front();
        if (taken.cmd == CMD_LOAD) begin
          if (taken.slot < KEY_DEPTH) begin
            round_keys[taken.slot] = taken.word;
          end
        end else begin
          expected_ciphertexts.push_back(rectangle_encrypt(taken.word));
        end
        offering     = 1'b0;
        gap_left     = idle_len();
        settle_count = 0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          head = cmd_queue[0];
          if (head.settle && settle_count < SETTLE_CYCLES) begin
            // Count quiet cycles only once nothing is left to come out.
            if (expected_ciphertexts.size() == 0) begin
              settle_count++;
            end else begin
              settle_count = 0;
            end
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid     <= 1'b1;
            in_ch.command   <= head.cmd;
            in_ch.key_slot  <= head.slot;
            in_ch.data_word <= head.word;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver. Each ciphertext beat is checked against the oldest
  // prediction. Ready drops for random stretches, and once, after a number of
  // results, for a long hold while the driver keeps offering beats, so that
  // the output buffer and the whole pipeline fill and input is stalled.
  // ---------------------------------------------------------------------------
  int stall_left;
  bit pressure_done;

  always @(posedge clk) begin
    logic [BLOCK_W-1:0] want;
    int                 n;
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      stall_left    = 0;
      pressure_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_ciphertexts.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected ciphertext %h", out_ch.ciphertext);
          end
        end else begin
          want = expected_ciphertexts.pop_front();
          if (out_ch.ciphertext !== want) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ciphertext mismatch: expected %h, got %h", want,
                       out_ch.ciphertext);
            end
          end
        end
      end
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        n = idle_len();
        if (n > 0) begin
          stall_left = n - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run in which no beat moves on either channel for too long has
  // hung, whatever the cause.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1'b1;
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat moved for %0d cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
